FILE: rtl/pancake_sorter_core_macros.svh
// Assertion macros used by the pancake sorter sequencer.
`ifndef PANCAKE_SORTER_CORE_MACROS_SVH
`define PANCAKE_SORTER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PCS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pcs_pkg.sv
// Shared types and constants of the pancake sorter.
package pcs_pkg;

   localparam int VALUE_W = 16;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Control group from the sequencer to the stack memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

FILE: rtl/pcs_mem.sv
// Stack memory: one write port and two registered read ports.
module pcs_mem #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  pcs_pkg::mem_ctl_type       ctl,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  pcs_pkg::value_type         wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0]   rd_b_addr,
   output pcs_pkg::value_type         rd_a_data,
   output pcs_pkg::value_type         rd_b_data
);

   pcs_pkg::value_type mem_ff [DEPTH];
   pcs_pkg::value_type rd_a_ff;
   pcs_pkg::value_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is enabled, so a swap can write both ends.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: rtl/pcs_cmp.sv
// Signed compare unit used by the maximum search.
module pcs_cmp (
   input  pcs_pkg::value_type cand,
   input  pcs_pkg::value_type best,
   input  logic               first,
   output logic               take
);

   // Strictly greater keeps the first index of equal maxima.
   assign take = first || (cand > best);

endmodule

FILE: rtl/pcs_seq.sv
// Sequencer: loads the stack, runs the pancake sort and drives the results.
`include "pancake_sorter_core_macros.svh"

module pcs_seq #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pcs_pkg::value_type         req_value,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_last_res,
   output pcs_pkg::mem_ctl_type       mem_ctl,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output pcs_pkg::value_type         wr_data,
   output logic [$clog2(DEPTH)-1:0]   rd_a_addr,
   output logic [$clog2(DEPTH)-1:0]   rd_b_addr,
   input  pcs_pkg::value_type         rd_a_data,
   input  pcs_pkg::value_type         rd_b_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_DECIDE   = 3'd2;
   localparam logic [2:0] ST_REV_RD   = 3'd3;
   localparam logic [2:0] ST_REV_WA   = 3'd4;
   localparam logic [2:0] ST_REV_WB   = 3'd5;
   localparam logic [2:0] ST_OUT_RD   = 3'd6;
   localparam logic [2:0] ST_OUT_SHOW = 3'd7;

   logic [2:0]         state_ff,     state_in;
   logic [CW-1:0]      count_ff,     count_in;
   logic [CW-1:0]      size_ff,      size_in;
   logic [CW-1:0]      scan_ff,      scan_in;
   logic [AW-1:0]      best_idx_ff,  best_idx_in;
   pcs_pkg::value_type best_val_ff,  best_val_in;
   logic [AW-1:0]      lo_ff,        lo_in;
   logic [AW-1:0]      hi_ff,        hi_in;
   logic               full_pend_ff, full_pend_in;
   logic [AW-1:0]      out_idx_ff,   out_idx_in;

   logic          req_fire;
   logic          rsp_fire;
   logic          has_room;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] size_m1;
   logic [CW-1:0] scan_m1;
   logic          scan_first;
   logic          take;

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign has_room   = (count_ff < CW'(DEPTH));
   assign count_inc  = has_room ? (count_ff + 1'b1) : count_ff;
   assign count_m1   = count_ff - 1'b1;
   assign size_m1    = size_ff - 1'b1;
   assign scan_m1    = scan_ff - 1'b1;
   assign scan_first = (scan_ff == CW'(1));

   pcs_cmp u_cmp (
      .cand  (rd_a_data),
      .best  (best_val_ff),
      .first (scan_first),
      .take  (take)
   );

   assign req_ready    = (state_ff == ST_LOAD);
   assign rsp_valid    = (state_ff == ST_OUT_SHOW);
   assign rsp_last_res = (CW'(out_idx_ff) == count_m1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      size_in      = size_ff;
      scan_in      = scan_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      full_pend_in = full_pend_ff;
      out_idx_in   = out_idx_ff;
      mem_ctl      = '0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_value;
      rd_a_addr    = lo_ff;
      rd_b_addr    = hi_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               mem_ctl.wr_en = has_room;
               count_in      = count_inc;
               if (req_last) begin
                  size_in    = count_inc;
                  scan_in    = '0;
                  out_idx_in = '0;
                  state_in   = (count_inc > CW'(1)) ? ST_SCAN : ST_OUT_RD;
               end
            end
         end
         ST_SCAN: begin
            // Reads are issued one ahead of the compare on the registered data.
            rd_a_addr     = scan_ff[AW-1:0];
            mem_ctl.rd_en = (scan_ff < size_ff);
            if (scan_ff != '0 && take) begin
               best_val_in = rd_a_data;
               best_idx_in = scan_m1[AW-1:0];
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == size_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            lo_in = '0;
            if (CW'(best_idx_ff) == size_m1) begin
               size_in  = size_m1;
               scan_in  = '0;
               state_in = (size_m1 > CW'(1)) ? ST_SCAN : ST_OUT_RD;
            end else if (best_idx_ff != '0) begin
               hi_in        = best_idx_ff;
               full_pend_in = 1'b1;
               state_in     = ST_REV_RD;
            end else begin
               hi_in        = size_m1[AW-1:0];
               full_pend_in = 1'b0;
               state_in     = ST_REV_RD;
            end
         end
         ST_REV_RD: begin
            if (lo_ff < hi_ff) begin
               mem_ctl.rd_en = 1'b1;
               state_in      = ST_REV_WA;
            end else if (full_pend_ff) begin
               lo_in        = '0;
               hi_in        = size_m1[AW-1:0];
               full_pend_in = 1'b0;
            end else begin
               size_in  = size_m1;
               scan_in  = '0;
               state_in = (size_m1 > CW'(1)) ? ST_SCAN : ST_OUT_RD;
            end
         end
         ST_REV_WA: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = lo_ff;
            wr_data       = rd_b_data;
            state_in      = ST_REV_WB;
         end
         ST_REV_WB: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = hi_ff;
            wr_data       = rd_a_data;
            lo_in         = lo_ff + 1'b1;
            hi_in         = hi_ff - 1'b1;
            state_in      = ST_REV_RD;
         end
         ST_OUT_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_a_addr     = out_idx_ff;
            state_in      = ST_OUT_SHOW;
         end
         ST_OUT_SHOW: begin
            if (rsp_fire) begin
               if (rsp_last_res) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  out_idx_in = out_idx_ff + 1'b1;
                  state_in   = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         size_ff      <= '0;
         scan_ff      <= '0;
         best_idx_ff  <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         full_pend_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         size_ff      <= size_in;
         scan_ff      <= scan_in;
         best_idx_ff  <= best_idx_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         full_pend_ff <= full_pend_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_val_ff <= best_val_in;
   end

   `PCS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "stored count above depth")
   `PCS_ASSERT_NOW(a_scan_size, state_ff == ST_SCAN, (size_ff > CW'(1)) && (size_ff <= count_ff), "prefix size out of range during scan")
   `PCS_ASSERT_NOW(a_swap_order, state_ff == ST_REV_WA || state_ff == ST_REV_WB, lo_ff < hi_ff, "swap with crossed indices")
   `PCS_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready, "input open while a result is shown")
   `PCS_ASSERT_NEXT(a_run_end, rsp_fire && rsp_last_res, (count_ff == '0) && req_ready, "run not cleared after final result")

endmodule

FILE: rtl/pancake_sorter_core.sv
// Top level of the pancake sorter: sequencer, compare unit and stack memory.
//
// A run of signed 16-bit values is loaded one transaction per cycle until a
// transaction with req_last set; values beyond DEPTH are dropped, and a last
// transaction that arrives when the stack is full still starts the sort. The
// stored n values are then pancake-sorted in place and returned in ascending
// order, with rsp_last_res set on the final one. The block does not accept
// input from the end of a run until its final result has been taken. For each
// prefix size s a single compare unit searches the maximum, and each reversal
// reads a pair, then writes its two ends in turn, because the stack has a
// single write port; each result is read from the memory before it is shown.
module pancake_sorter_core #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pcs_pkg::value_type req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pcs_pkg::value_type rsp_value_res,
   output logic               rsp_last_res
);

   localparam int AW = $clog2(DEPTH);

   pcs_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]        wr_addr;
   pcs_pkg::value_type   wr_data;
   logic [AW-1:0]        rd_a_addr;
   logic [AW-1:0]        rd_b_addr;
   pcs_pkg::value_type   rd_a_data;
   pcs_pkg::value_type   rd_b_data;

   pcs_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_last_res (rsp_last_res),
      .mem_ctl      (mem_ctl),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_a_addr    (rd_a_addr),
      .rd_b_addr    (rd_b_addr),
      .rd_a_data    (rd_a_data),
      .rd_b_data    (rd_b_data)
   );

   pcs_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock     (clock),
      .ctl       (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // The result value is the memory's registered read data, held while shown.
   assign rsp_value_res = rd_a_data;

endmodule

FILE: tb/tb_pancake_sorter_core.sv
// Self-checking testbench for pancake_sorter_core with directed and random runs.
`timescale 1ns / 100ps

module tb_pancake_sorter_core;

   localparam int DEPTH = 16;
   // Longest quiet stretch allowed: a full sort of DEPTH values plus margin.
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES = 2 * DEPTH * DEPTH + 100;

   typedef struct {
      pcs_pkg::value_type value;
      logic               last;
   } sorted_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   pcs_pkg::value_type req_value = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   pcs_pkg::value_type rsp_value_res;
   logic               rsp_last_res;

   // Mirror of the block's stack and fill level, plus the sorted values still owed.
   pcs_pkg::value_type stack_mirror [DEPTH];
   int unsigned        stack_fill = 0;
   sorted_entry_type   expected_sorted [$];

   int unsigned send_gap_max = 5;
   int unsigned rsp_stall_max = 5;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;

   pancake_sorter_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value_res(rsp_value_res),
      .rsp_last_res (rsp_last_res)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void flip_prefix(input int unsigned top);
      int unsigned        lo;
      int unsigned        hi;
      pcs_pkg::value_type held;
      lo = 0;
      hi = top;
      while (lo < hi) begin
         held = stack_mirror[lo];
         stack_mirror[lo] = stack_mirror[hi];
         stack_mirror[hi] = held;
         lo++;
         hi--;
      end
   endfunction

   // Stores one value and, at the end of a run, pancake-sorts the mirror and
   // queues the ascending values the block owes.
   function automatic void absorb_value(input pcs_pkg::value_type v, input logic lst);
      int unsigned      size;
      int unsigned      peak;
      int unsigned      i;
      int unsigned      k;
      sorted_entry_type entry;
      if (stack_fill < DEPTH) begin
         stack_mirror[stack_fill] = v;
         stack_fill++;
      end
      if (lst) begin
         for (size = stack_fill; size > 1; size--) begin
            peak = 0;
            for (i = 1; i < size; i++) begin
               if (stack_mirror[i] > stack_mirror[peak]) peak = i;
            end
            if (peak != size - 1) begin
               if (peak > 0) flip_prefix(peak);
               flip_prefix(size - 1);
            end
         end
         for (k = 0; k < stack_fill; k++) begin
            entry.value = stack_mirror[k];
            entry.last = (k + 1 == stack_fill);
            expected_sorted.push_back(entry);
         end
         stack_fill = 0;
      end
   endfunction

   task automatic send_item(input pcs_pkg::value_type v, input logic lst);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last <= lst;
      do @(posedge clock); while (!req_ready);
      absorb_value(v, lst);
   endtask

   // The sender holds off until every owed result has been taken.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic test_single_value();
      send_item(16'h7fff, 1'b1);
   endtask

   // Repeated maxima and both extremes of the signed 16-bit range.
   task automatic test_duplicates_and_extremes();
      send_item(16'sd7, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'sd7, 1'b0);
      send_item(16'h7fff, 1'b0);
      send_item(16'hffff, 1'b0);
      send_item(16'sd7, 1'b1);
   endtask

   // Sixteen values fill the stack; the closing transaction is dropped but still
   // starts the sort.
   task automatic test_overflow_run();
      pcs_pkg::value_type fill [DEPTH];
      int unsigned        j;
      fill = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa,
               16'sd100, 16'sd100, -16'sd100, 16'h7fff, 16'h8000, 16'sd12345,
               -16'sd12345, 16'h0000, 16'sd7};
      for (j = 0; j < DEPTH; j++) send_item(fill[j], 1'b0);
      send_item(16'sd999, 1'b1);
   endtask

   task automatic test_random_runs(input int unsigned quota, input int unsigned gap_max,
                                   input int unsigned stall_max, input bit hold);
      int unsigned        stored;
      int unsigned        len;
      int unsigned        style;
      int unsigned        j;
      pcs_pkg::value_type v;
      pcs_pkg::value_type base;
      send_gap_max = gap_max;
      rsp_stall_max = stall_max;
      stored = 0;
      while (stored < quota) begin
         // Mostly well-formed runs; now and then one that overflows the stack.
         if ($urandom_range(0, 9) == 0) len = $urandom_range(DEPTH + 1, DEPTH + 4);
         else len = $urandom_range(1, DEPTH);
         style = $urandom_range(0, 3);
         base = pcs_pkg::value_type'($urandom);
         for (j = 0; j < len; j++) begin
            case (style)
               0: v = pcs_pkg::value_type'($urandom);
               1: v = pcs_pkg::value_type'(int'($urandom_range(0, 6)) - 3);
               2: begin
                  case ($urandom_range(0, 3))
                     0: v = 16'h8000;
                     1: v = 16'h7fff;
                     2: v = 16'h0000;
                     default: v = 16'hffff;
                  endcase
               end
               default: v = base + pcs_pkg::value_type'(j * 3);
            endcase
            send_item(v, j == len - 1);
         end
         stored += (len < DEPTH) ? len : DEPTH;
         if (hold) wait_for_drain();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_single_value();
      test_duplicates_and_extremes();
      test_overflow_run();
      test_random_runs(75, 5, 5, 1'b0);
      test_random_runs(50, 0, 0, 1'b0);
      test_random_runs(50, 5, 5, 1'b1);
      test_random_runs(65, 3, 5, 1'b0);
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_sorted.size() != 0) begin
         $error("%0d sorted values never arrived", expected_sorted.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("pancake_sorter_core: match");
      end else begin
         $display("pancake_sorter_core: mismatch");
      end
      $finish;
   end

   // Result side: a random stall before each transaction, none in burst phases.
   initial begin
      int unsigned stall;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin : result_check
      sorted_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sorted.size() == 0) begin
            $error("unexpected result: value_res %0d, last_res %0b", rsp_value_res,
                   rsp_last_res);
            fail_count++;
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_value_res !== want.value) begin
               $error("value_res: expected %0d, got %0d", want.value, rsp_value_res);
               fail_count++;
            end
            if (rsp_last_res !== want.last) begin
               $error("last_res: expected %0b, got %0b", want.last, rsp_last_res);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("pancake_sorter_core: mismatch");
         $finish;
      end
   end

endmodule

FILE: pancake_sorter_core.f
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pcs_mem.sv
rtl/pcs_cmp.sv
rtl/pcs_seq.sv
rtl/pancake_sorter_core.sv
tb/tb_pancake_sorter_core.sv
